@@ rtl/core/gpsr_pkg.sv @@
// ----------------------------------------------------------------------------
// GPIO port with serial RTC - shared definitions
// Types, codes and constants used by the step logic and the top level.
// ----------------------------------------------------------------------------
package gpsr_pkg;

  // Register addresses of the port.
  typedef enum logic [1:0] {
    REG_DATA = 2'd0,
    REG_DIR  = 2'd1,
    REG_CTRL = 2'd2,
    REG_NONE = 2'd3
  } gpsr_reg_e;

  // Bus access kind.
  typedef enum logic {
    ACC_WRITE = 1'b0,
    ACC_READ  = 1'b1
  } gpsr_acc_e;

  // Command kinds in bits 6:4 of the command byte.
  localparam logic [2:0] KIND_RESET    = 3'd0;
  localparam logic [2:0] KIND_DATETIME = 3'd2;
  localparam logic [2:0] KIND_CONTROL  = 3'd4;
  localparam logic [2:0] KIND_TIME     = 3'd6;

  localparam logic [3:0] MAGIC_NIBBLE  = 4'h6;
  localparam logic [7:0] CONTROL_RESET = 8'h40;
  localparam logic [3:0] PIN_MASK      = 4'hF;
  localparam logic [3:0] BIT_COUNT_MAX = 4'hF;
  localparam logic [3:0] BITS_PER_BYTE = 4'd8;

  localparam int unsigned TIME_BYTES = 7;

  // Pin positions.
  localparam int unsigned PIN_SCK = 0;
  localparam int unsigned PIN_SIO = 1;
  localparam int unsigned PIN_CS  = 2;

  // Complete state of the port and the clock chip.
  typedef struct packed {
    logic [3:0]                       out_latch;
    logic [3:0]                       dir_mask;
    logic [3:0]                       pin_state;
    logic                             readable;
    logic                             prev_sck;
    logic                             sio_drive;
    logic [7:0]                       shift_byte;
    logic [3:0]                       bit_count;
    logic [2:0]                       bytes_left;
    logic                             command_active;
    logic [7:0]                       command_byte;
    logic [TIME_BYTES-1:0][7:0]       time_bytes;
    logic [7:0]                       clock_control;
  } gpsr_state_t;

  localparam gpsr_state_t STATE_RESET = '{
    out_latch:      4'h0,
    dir_mask:       4'h0,
    pin_state:      4'h0,
    readable:       1'b0,
    prev_sck:       1'b1,
    sio_drive:      1'b1,
    shift_byte:     8'h00,
    bit_count:      4'h0,
    bytes_left:     3'd0,
    command_active: 1'b0,
    command_byte:   8'h00,
    time_bytes:     '0,
    clock_control:  CONTROL_RESET
  };

  // Number of data bytes that follow a command of the given kind.
  function automatic logic [2:0] byte_count(input logic [2:0] kind);
    logic [2:0] cnt;
    case (kind)
      KIND_DATETIME: cnt = 3'd7;
      KIND_CONTROL:  cnt = 3'd1;
      KIND_TIME:     cnt = 3'd3;
      default:       cnt = 3'd0;
    endcase
    return cnt;
  endfunction

endpackage

@@ rtl/core/gpsr_step.sv @@
// ----------------------------------------------------------------------------
// GPIO port with serial RTC - access step logic
// Computes the next port and clock state and the result of one bus access.
// ----------------------------------------------------------------------------
module gpsr_step (
  input  gpsr_pkg::gpsr_state_t state_i,
  input  logic                  cmd_i,
  input  logic [1:0]            reg_select_i,
  input  logic [15:0]           write_data_i,
  input  logic [55:0]           current_time_i,
  output gpsr_pkg::gpsr_state_t state_o,
  output logic [3:0]            read_data_o,
  output logic [3:0]            pin_levels_o
);

  gpsr_pkg::gpsr_state_t s;
  logic [3:0] pins;
  logic [3:0] undriven;
  logic       sck;
  logic       sio;
  logic [2:0] kind;
  logic [2:0] new_kind;
  logic [3:0] bc_next;
  logic [7:0] out_byte;
  logic [2:0] byte_idx;
  logic       pin_write;

  always_comb begin
    s           = state_i;
    read_data_o = '0;
    pins        = '0;
    undriven    = '0;
    sck         = 1'b0;
    sio         = 1'b0;
    kind        = state_i.command_byte[6:4];
    new_kind    = state_i.shift_byte[6:4];
    bc_next     = state_i.bit_count;
    out_byte    = 8'hFF;
    byte_idx    = '0;
    pin_write   = 1'b0;

    // Register access.
    if (cmd_i == gpsr_pkg::ACC_READ) begin
      if (state_i.readable) begin
        case (reg_select_i)
          gpsr_pkg::REG_DATA: read_data_o = state_i.pin_state;
          gpsr_pkg::REG_DIR:  read_data_o = state_i.dir_mask;
          gpsr_pkg::REG_CTRL: read_data_o = {3'b000, state_i.readable};
          default:            read_data_o = '0;
        endcase
      end
    end else begin
      case (reg_select_i)
        gpsr_pkg::REG_DATA: begin
          s.out_latch = write_data_i[3:0] & gpsr_pkg::PIN_MASK;
          pin_write   = 1'b1;
        end
        gpsr_pkg::REG_DIR: begin
          s.dir_mask = write_data_i[3:0] & gpsr_pkg::PIN_MASK;
          pin_write  = 1'b1;
        end
        gpsr_pkg::REG_CTRL: s.readable = write_data_i[0];
        default: ;
      endcase
    end

    // Pin update and serial clock logic after a data or direction write.
    if (pin_write) begin
      undriven = ~s.dir_mask & gpsr_pkg::PIN_MASK;
      // Driven pins follow the latch; undriven SIO keeps its level, others read low.
      pins = (s.out_latch & s.dir_mask) | (state_i.pin_state & undriven & 4'b0010);

      if (!pins[gpsr_pkg::PIN_CS]) begin
        // Chip select low: abort the transfer and release SIO high.
        s.bit_count      = '0;
        s.bytes_left     = '0;
        s.command_active = 1'b0;
        s.shift_byte     = '0;
        s.prev_sck       = 1'b1;
        s.sio_drive      = 1'b1;
        pins             = (pins & s.dir_mask) | (4'b0010 & undriven);
      end else if (!s.command_active || !s.command_byte[7]) begin
        // Host to clock: sample SIO while SCK is low, advance the bit counter on rising SCK.
        pins = (pins & s.dir_mask) | (4'b0010 & undriven);
        sck  = pins[gpsr_pkg::PIN_SCK];
        sio  = pins[gpsr_pkg::PIN_SIO];
        if (!sck && !s.bit_count[3]) begin
          s.shift_byte[s.bit_count[2:0]] = sio;
        end
        if (!s.prev_sck && sck) begin
          if (!s.command_active) begin
            if (s.bit_count != gpsr_pkg::BIT_COUNT_MAX) begin
              s.bit_count = s.bit_count + 4'd1;
            end
            if (s.bit_count == gpsr_pkg::BITS_PER_BYTE &&
                s.shift_byte[3:0] == gpsr_pkg::MAGIC_NIBBLE) begin
              // A valid command byte has been received.
              s.command_byte   = s.shift_byte;
              s.bytes_left     = gpsr_pkg::byte_count(new_kind);
              s.command_active = 1'b1;
              if (s.shift_byte[7] &&
                  (new_kind inside {gpsr_pkg::KIND_DATETIME, gpsr_pkg::KIND_TIME})) begin
                for (int i = 0; i < gpsr_pkg::TIME_BYTES; i++) begin
                  s.time_bytes[i] = current_time_i[(gpsr_pkg::TIME_BYTES-1-i)*8 +: 8];
                end
              end
              if (new_kind == gpsr_pkg::KIND_RESET) begin
                s.clock_control = '0;
              end
              s.shift_byte = '0;
              s.bit_count  = '0;
            end
          end else begin
            if (!s.bit_count[3] && !sio) begin
              s.shift_byte[s.bit_count[2:0]] = 1'b0;
            end
            bc_next     = s.bit_count + 4'd1;
            s.bit_count = bc_next;
            if (bc_next == gpsr_pkg::BITS_PER_BYTE) begin
              // Data byte complete.
              if (kind == gpsr_pkg::KIND_CONTROL) begin
                s.clock_control = s.shift_byte;
              end
              s.shift_byte = '0;
              s.bit_count  = '0;
              if (s.bytes_left <= 3'd1) begin
                s.bytes_left = gpsr_pkg::byte_count(kind);
              end else begin
                s.bytes_left = s.bytes_left - 3'd1;
              end
            end
          end
        end
        s.prev_sck = pins[gpsr_pkg::PIN_SCK];
      end else begin
        // Clock to host: shift a bit out on each falling SCK edge.
        sck = pins[gpsr_pkg::PIN_SCK];
        if (s.prev_sck && !sck) begin
          byte_idx = 3'd7 - s.bytes_left;
          if (kind == gpsr_pkg::KIND_CONTROL) begin
            out_byte = s.clock_control;
          end else if ((kind inside {gpsr_pkg::KIND_DATETIME, gpsr_pkg::KIND_TIME}) &&
                       s.bytes_left != 3'd0) begin
            out_byte = s.time_bytes[byte_idx];
          end
          s.sio_drive = out_byte[s.bit_count[2:0]];
          bc_next     = s.bit_count + 4'd1;
          s.bit_count = bc_next;
          if (bc_next[3]) begin
            if (s.bytes_left <= 3'd1) begin
              s.bytes_left = gpsr_pkg::byte_count(kind);
            end else begin
              s.bytes_left = s.bytes_left - 3'd1;
            end
            s.bit_count = '0;
          end
        end
        pins       = (pins & s.dir_mask) | ({2'b00, s.sio_drive, 1'b0} & undriven);
        s.prev_sck = pins[gpsr_pkg::PIN_SCK];
      end
      s.pin_state = pins;
    end

    state_o      = s;
    pin_levels_o = s.pin_state;
  end

endmodule

@@ rtl/core/gpio_port_serial_rtc.sv @@
// ----------------------------------------------------------------------------
// GPIO port with serial RTC - top level
// Each request is held in the input register; its result is registered in the
// result register once that register is free to take it.
// Throughput: one request per cycle when results are taken; input and result
// registers let a new request enter while a result waits to be taken.
// Reset: asynchronous, active low; clears the port, the transfer state and
// the time bytes, and sets the clock control register to CONTROL_RESET.
// ----------------------------------------------------------------------------
module gpio_port_serial_rtc (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [15:0] write_data, [71:16] current_time
  input  logic [71:0] s_axis_tdata,
  // [0] cmd, [2:1] reg_select
  input  logic [2:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [3:0] read_data, [7:4] pin_levels
  output logic [7:0]  m_axis_tdata
);

  logic                  in_valid_q;
  logic                  cmd_q;
  logic [1:0]            reg_select_q;
  logic [15:0]           write_data_q;
  logic [55:0]           current_time_q;
  logic                  out_valid_q;
  logic [3:0]            read_data_q;
  logic [3:0]            pin_levels_q;
  gpsr_pkg::gpsr_state_t state_q;
  gpsr_pkg::gpsr_state_t state_d;
  logic [3:0]            read_data_d;
  logic [3:0]            pin_levels_d;
  logic                  advance;
  logic                  in_take;

  // Flow control between the input and result registers.
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  // Access logic.
  gpsr_step u_step (
    .state_i        (state_q),
    .cmd_i          (cmd_q),
    .reg_select_i   (reg_select_q),
    .write_data_i   (write_data_q),
    .current_time_i (current_time_q),
    .state_o        (state_d),
    .read_data_o    (read_data_d),
    .pin_levels_o   (pin_levels_d)
  );

  // Control registers and port state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= gpsr_pkg::STATE_RESET;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        state_q     <= state_d;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Request and result payload registers.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      cmd_q          <= s_axis_tuser[0];
      reg_select_q   <= s_axis_tuser[2:1];
      write_data_q   <= s_axis_tdata[15:0];
      current_time_q <= s_axis_tdata[71:16];
    end
    if (advance) begin
      read_data_q  <= read_data_d;
      pin_levels_q <= pin_levels_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {pin_levels_q, read_data_q};

endmodule
